[src/plrt_pkg.sv]
// plrt_pkg: sizes, item codes and helpers for the position limit risk table
// used by position_limit_risk_table_top and plrt_checker
package plrt_pkg;

    localparam int NUM_SYMBOLS = 64;
    localparam int POS_WIDTH   = 48;
    localparam int SYM_AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    localparam int KIND_W  = 2;
    localparam int SYM_W   = 6;
    localparam int QTY_W   = 32;
    localparam int LIMIT_W = 47;
    localparam int OUT_W   = 48;
    localparam int CMP_W   = ((POS_WIDTH > LIMIT_W) ? POS_WIDTH : LIMIT_W) + 1;

    localparam int ENTRY_W = 3 * POS_WIDTH;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ORDER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;

    typedef logic signed [POS_WIDTH-1:0] t_pos;
    typedef logic signed [OUT_W-1:0]     t_out;

    typedef struct packed {
        t_pos open_sell;
        t_pos open_buy;
        t_pos net;
    } t_entry;

    function automatic t_out to_out(input t_pos v);
        return OUT_W'(v);
    endfunction

endpackage

[src/plrt_ram.sv]
// plrt_ram: generic single write port, single read port ram with registered read
// no package dependencies
module plrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/position_limit_risk_table_top.sv]
// position_limit_risk_table_top: pre-trade position limit check over a table of instruments
// depends on plrt_pkg and plrt_ram
// input beat and ram read are registered, then the result once the output register is free
// a new item is taken only after the last one's read then modify-write of the entry ram
// a waiting result does not block the next input beat
// reset: synchronous active low; table entries read as zero until first written (valid bits)
// reset sets position_limit to 10000 and empties the pipeline
module position_limit_risk_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [39:0]                    i_s_axis_tdata,  // symbol_index, quantity, zero pad
    input  logic [2:0]                     i_s_axis_tuser,  // kind, side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [143:0]                   o_m_axis_tdata,  // net_pos, open_buy, open_sell
    output logic [0:0]                     o_m_axis_tuser,  // allowed
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plrt_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import plrt_pkg::*;

    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_busy;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_sell;
    logic [QTY_W-1:0]     r_qty;
    logic [SYM_AW-1:0]    r_addr;
    logic                 r_in_range;
    logic                 r_hit;
    logic                 r_valid [NUM_SYMBOLS];
    logic                 r_out_valid;
    logic                 r_out_allowed;
    t_out                 r_out_net;
    t_out                 r_out_buy;
    t_out                 r_out_sell;

    logic                 s_accept;
    logic                 done;
    logic [SYM_W-1:0]     in_sym;
    logic [SYM_AW-1:0]    in_addr;
    logic                 in_range;
    logic [ENTRY_W-1:0]   rd_data;
    t_entry               cur;
    t_entry               upd;
    t_pos                 qty_ext;
    t_pos                 proj;
    t_pos                 mag;
    logic                 allowed;
    logic                 wr_en;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_busy;
    assign o_cfg_ready     = 1'b1;
    assign done            = r_busy && (!r_out_valid || i_m_axis_tready);

    assign in_sym   = i_s_axis_tdata[SYM_W-1:0];
    assign in_addr  = SYM_AW'(in_sym);
    assign in_range = ({1'b0, in_sym} < (SYM_W + 1)'(NUM_SYMBOLS));

    plrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (upd),
        .i_rd_en   (s_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        cur     = r_hit ? t_entry'(rd_data) : '0;
        upd     = cur;
        qty_ext = t_pos'({{(POS_WIDTH - QTY_W){1'b0}}, r_qty});
        proj    = r_sell ? (cur.net - qty_ext - cur.open_sell)
                         : (cur.net + qty_ext + cur.open_buy);
        mag     = proj[POS_WIDTH-1] ? (-proj) : proj;
        allowed = 1'b0;
        wr_en   = 1'b0;
        case (r_kind)
            KIND_CHECK: begin
                allowed = (CMP_W'(unsigned'(mag)) <= CMP_W'(r_limit));
            end
            KIND_ORDER: begin
                wr_en = done && r_in_range;
                if (r_sell) begin
                    upd.open_sell = cur.open_sell + qty_ext;
                end else begin
                    upd.open_buy = cur.open_buy + qty_ext;
                end
            end
            KIND_FILL: begin
                wr_en = done && r_in_range;
                if (r_sell) begin
                    upd.net       = cur.net - qty_ext;
                    upd.open_sell = cur.open_sell - qty_ext;
                end else begin
                    upd.net      = cur.net + qty_ext;
                    upd.open_buy = cur.open_buy - qty_ext;
                end
            end
            default: begin
                allowed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (s_accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind     <= i_s_axis_tuser[KIND_W-1:0];
            r_sell     <= i_s_axis_tuser[KIND_W];
            r_qty      <= i_s_axis_tdata[SYM_W +: QTY_W];
            r_addr     <= in_addr;
            r_in_range <= in_range;
            r_hit      <= in_range ? r_valid[in_addr] : 1'b0;
        end
        if (done) begin
            r_out_allowed <= r_in_range && allowed;
            r_out_net     <= r_in_range ? to_out(upd.net) : '0;
            r_out_buy     <= r_in_range ? to_out(upd.open_buy) : '0;
            r_out_sell    <= r_in_range ? to_out(upd.open_sell) : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_sell, r_out_buy, r_out_net};
    assign o_m_axis_tuser  = r_out_allowed;

endmodule

[src/plrt_checker.sv]
// plrt_checker: port-level assertions for position_limit_risk_table_top
// depends on plrt_pkg; bound to the top level below
module plrt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [143:0]                 o_m_axis_tdata,
    input logic [0:0]                   o_m_axis_tuser,
    input logic                         o_cfg_ready
);
    import plrt_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second input beat taken while an item is in flight");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !$past(o_m_axis_tvalid)) |-> !$past(o_s_axis_tready))
        else $error("result beat without an item in flight");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind position_limit_risk_table_top plrt_checker u_plrt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_cfg_ready     (o_cfg_ready)
);
